// ===== hdl/cbpe_pkg.sv =====
// Shared constants and types for the cubic Bezier point evaluator.
package cbpe_pkg;

	localparam int NUM_POINTS     = 4;
	localparam int NUM_AXES       = 3;
	localparam int POINT_IDX_BITS = 2;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QUEUE_PTR_BITS = 2;
	localparam int QUEUE_CNT_BITS = 3;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_EVAL = 1'b1;

	localparam logic [NUM_POINTS-1:0] ALL_LOADED = {NUM_POINTS{1'b1}};

	typedef struct packed {
		logic not_empty;
		logic full;
	} cbpe_q_status_t;

endpackage

// ===== hdl/cbpe_front.sv =====
// Front end: accepts items, stores control points and queues evaluate jobs.
module cbpe_front #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 16,
	parameter int IN_W       = 72,
	parameter int ENTRY_W    = 1 + FRAC_BITS + 1 + 12 * COORD_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_W-1:0]        s_tdata,
	input  logic                   s_tuser,
	input  cbpe_pkg::cbpe_q_status_t q_status,
	output logic                   push,
	output logic [ENTRY_W-1:0]     push_data
);
	import cbpe_pkg::*;

	localparam int X_LO = POINT_IDX_BITS;
	localparam int Y_LO = X_LO + COORD_BITS;
	localparam int Z_LO = Y_LO + COORD_BITS;
	localparam int T_LO = Z_LO + COORD_BITS;
	localparam logic [FRAC_BITS:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

	logic [NUM_AXES-1:0][NUM_POINTS-1:0][COORD_BITS-1:0] pts_q;
	logic [NUM_POINTS-1:0]     loaded_q;
	logic                      accept;
	logic                      is_load;
	logic [POINT_IDX_BITS-1:0] idx;
	logic [FRAC_BITS:0]        t_raw;
	logic [FRAC_BITS:0]        t_sat;
	logic                      missing;

	assign s_tready = !q_status.full;
	assign accept   = s_tvalid && s_tready;
	assign is_load  = (s_tuser == FUNC_LOAD);
	assign idx      = s_tdata[POINT_IDX_BITS-1:0];
	assign t_raw    = s_tdata[T_LO+FRAC_BITS:T_LO];
	assign t_sat    = (t_raw > T_ONE) ? T_ONE : t_raw;
	assign missing  = (loaded_q != ALL_LOADED);

	assign push      = accept && (s_tuser == FUNC_EVAL);
	assign push_data = {missing, t_sat, pts_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
		end else if (accept && is_load) begin
			loaded_q[idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_load) begin
			pts_q[0][idx] <= s_tdata[X_LO+COORD_BITS-1:X_LO];
			pts_q[1][idx] <= s_tdata[Y_LO+COORD_BITS-1:Y_LO];
			pts_q[2][idx] <= s_tdata[Z_LO+COORD_BITS-1:Z_LO];
		end
	end

endmodule

// ===== hdl/cbpe_queue.sv =====
// Short job queue between the front end and the interpolation pipeline.
module cbpe_queue #(
	parameter int ENTRY_W = 210
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [ENTRY_W-1:0]     push_data,
	input  logic                   pop,
	output logic [ENTRY_W-1:0]     head_data,
	output cbpe_pkg::cbpe_q_status_t q_status
);
	import cbpe_pkg::*;

	logic [ENTRY_W-1:0]        mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [QUEUE_CNT_BITS-1:0] count_q;
	logic                      do_push;
	logic                      do_pop;

	assign q_status.not_empty = (count_q != '0);
	assign q_status.full      = (count_q == QUEUE_CNT_BITS'(QUEUE_DEPTH));
	assign do_push   = push && !q_status.full;
	assign do_pop    = pop && q_status.not_empty;
	assign head_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== hdl/cbpe_back.sv =====
// Back end: three de Casteljau interpolation levels and the output register.
module cbpe_back #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 16,
	parameter int OUT_W      = 48,
	parameter int ENTRY_W    = 1 + FRAC_BITS + 1 + 12 * COORD_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  logic [ENTRY_W-1:0] head_data,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_W-1:0]   m_tdata,
	output logic               m_tuser
);
	import cbpe_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int PW = COORD_BITS + FRAC_BITS + 2;
	localparam int PTS_W = NUM_AXES * NUM_POINTS * COORD_BITS;

	logic [NUM_AXES-1:0][NUM_POINTS-1:0][C-1:0] head_pts;
	logic [FRAC_BITS:0] head_t;
	logic               head_miss;
	logic               en;

	logic                       v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                       miss_s1, miss_s2, miss_s3, miss_s4, miss_s5;
	logic [FRAC_BITS:0]         t_s1, t_s2, t_s3, t_s4;
	logic [NUM_AXES-1:0][2:0][C-1:0]  a_s1;
	logic [NUM_AXES-1:0][2:0][PW-1:0] p_s1;
	logic [NUM_AXES-1:0][2:0][C-1:0]  l1_s2;
	logic [NUM_AXES-1:0][1:0][C-1:0]  a_s3;
	logic [NUM_AXES-1:0][1:0][PW-1:0] p_s3;
	logic [NUM_AXES-1:0][1:0][C-1:0]  l2_s4;
	logic [NUM_AXES-1:0][C-1:0]       a_s5;
	logic [NUM_AXES-1:0][PW-1:0]      p_s5;
	logic [NUM_AXES-1:0][C-1:0]       res_q;
	logic                       m_tvalid_q;
	logic                       m_tuser_q;

	logic [NUM_AXES-1:0][2:0][PW-1:0] p1_d;
	logic [NUM_AXES-1:0][2:0][C-1:0]  l1_d;
	logic [NUM_AXES-1:0][1:0][PW-1:0] p2_d;
	logic [NUM_AXES-1:0][1:0][C-1:0]  l2_d;
	logic [NUM_AXES-1:0][PW-1:0]      p3_d;
	logic [NUM_AXES-1:0][C-1:0]       l3_d;
	logic signed [FRAC_BITS+1:0] tsg0, tsg2, tsg4;

	assign head_pts  = head_data[PTS_W-1:0];
	assign head_t    = head_data[PTS_W+FRAC_BITS:PTS_W];
	assign head_miss = head_data[ENTRY_W-1];

	assign en  = !m_tvalid_q || m_tready;
	assign pop = en && head_valid;

	assign tsg0 = $signed({1'b0, head_t});
	assign tsg2 = $signed({1'b0, t_s2});
	assign tsg4 = $signed({1'b0, t_s4});

	always_comb begin
		logic [C:0] d;
		logic signed [PW-1:0] sh;
		d  = '0;
		sh = '0;
		for (int ax = 0; ax < NUM_AXES; ax++) begin
			for (int i = 0; i < 3; i++) begin
				d = {head_pts[ax][i+1][C-1], head_pts[ax][i+1]}
				    - {head_pts[ax][i][C-1], head_pts[ax][i]};
				p1_d[ax][i] = PW'($signed(d) * tsg0);
				sh = $signed(p_s1[ax][i]) >>> FRAC_BITS;
				l1_d[ax][i] = a_s1[ax][i] + sh[C-1:0];
			end
			for (int j = 0; j < 2; j++) begin
				d = {l1_s2[ax][j+1][C-1], l1_s2[ax][j+1]}
				    - {l1_s2[ax][j][C-1], l1_s2[ax][j]};
				p2_d[ax][j] = PW'($signed(d) * tsg2);
				sh = $signed(p_s3[ax][j]) >>> FRAC_BITS;
				l2_d[ax][j] = a_s3[ax][j] + sh[C-1:0];
			end
			d = {l2_s4[ax][1][C-1], l2_s4[ax][1]} - {l2_s4[ax][0][C-1], l2_s4[ax][0]};
			p3_d[ax] = PW'($signed(d) * tsg4);
			sh = $signed(p_s5[ax]) >>> FRAC_BITS;
			l3_d[ax] = a_s5[ax] + sh[C-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			v_s5       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			v_s1       <= head_valid;
			v_s2       <= v_s1;
			v_s3       <= v_s2;
			v_s4       <= v_s3;
			v_s5       <= v_s4;
			m_tvalid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			miss_s1 <= head_miss;
			t_s1    <= head_t;
			p_s1    <= p1_d;
			for (int ax = 0; ax < NUM_AXES; ax++) begin
				for (int i = 0; i < 3; i++) begin
					a_s1[ax][i] <= head_pts[ax][i];
				end
			end
			miss_s2 <= miss_s1;
			t_s2    <= t_s1;
			l1_s2   <= l1_d;
			miss_s3 <= miss_s2;
			t_s3    <= t_s2;
			p_s3    <= p2_d;
			for (int ax = 0; ax < NUM_AXES; ax++) begin
				for (int j = 0; j < 2; j++) begin
					a_s3[ax][j] <= l1_s2[ax][j];
				end
			end
			miss_s4 <= miss_s3;
			t_s4    <= t_s3;
			l2_s4   <= l2_d;
			miss_s5 <= miss_s4;
			p_s5    <= p3_d;
			for (int ax = 0; ax < NUM_AXES; ax++) begin
				a_s5[ax] <= l2_s4[ax][0];
			end
			m_tuser_q <= miss_s5;
			res_q     <= miss_s5 ? '0 : l3_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = OUT_W'({res_q[2], res_q[1], res_q[0]});

endmodule

// ===== hdl/cubic_bezier_point_evaluator.sv =====
// Top level of the cubic Bezier point evaluator.
//
// Input channel s_*: each item is a load (tuser 0) or an evaluate (tuser 1).
// A load writes one of four control points and gives no result. An evaluate
// gives one result item on m_*: the curve point at t by de Casteljau
// interpolation, or all-zero coordinates with tuser set if any of the four
// control points has not yet been loaded. t above one saturates to one.
// Loads and evaluates may follow each other in any order; an evaluate uses
// the points as they stood when it was accepted.
// Throughput: one item per cycle while m_tready is high. A result passes
// through the job queue and then the six-stage interpolation pipeline
// (a multiply stage and a shift-add stage per level).
// Reset clears the loaded marks, the job queue and all pipeline valids; point
// coordinates are not cleared. While a result waits with m_tready low the whole
// pipeline holds; the four-entry job queue keeps taking items until it fills,
// then s_tready drops until the pipeline moves again.
module cubic_bezier_point_evaluator #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// point_index, x_in, y_in, z_in, curve_param, zero fill
	input  logic [((2 + 3 * COORD_BITS + FRAC_BITS + 1 + 7) / 8) * 8 - 1:0] s_tdata,
	// func
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// x_out, y_out, z_out, zero fill
	output logic [((3 * COORD_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	// missing_points
	output logic m_tuser
);
	import cbpe_pkg::*;

	localparam int IN_W    = ((2 + 3 * COORD_BITS + FRAC_BITS + 1 + 7) / 8) * 8;
	localparam int OUT_W   = ((3 * COORD_BITS + 7) / 8) * 8;
	localparam int ENTRY_W = 1 + FRAC_BITS + 1 + NUM_AXES * NUM_POINTS * COORD_BITS;

	cbpe_q_status_t     q_status;
	logic               push;
	logic [ENTRY_W-1:0] push_data;
	logic               pop;
	logic [ENTRY_W-1:0] head_data;

	cbpe_front #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS),
		.IN_W      (IN_W),
		.ENTRY_W   (ENTRY_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_status (q_status),
		.push     (push),
		.push_data(push_data)
	);

	cbpe_queue #(
		.ENTRY_W(ENTRY_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head_data(head_data),
		.q_status (q_status)
	);

	cbpe_back #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS),
		.OUT_W     (OUT_W),
		.ENTRY_W   (ENTRY_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(q_status.not_empty),
		.head_data (head_data),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	a_missing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("missing-point result carries nonzero coordinates");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_status.not_empty)
		else $error("queue popped while empty");

	a_stall_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !pop)
		else $error("queue popped while output stalled");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.full && !pop |=> q_status.full)
		else $error("queue drained without a pop");

endmodule

// ===== test/tb_cubic_bezier_point_evaluator.sv =====
// Testbench for the cubic Bezier point evaluator: directed and random items against a predictor.
module tb_cubic_bezier_point_evaluator;
	timeunit 1ns;
	timeprecision 1ps;

	import cbpe_pkg::*;

	localparam int     COORD_BITS = 16;
	localparam int     FRAC_BITS  = 16;
	localparam int     S_WIDTH    = 72;
	localparam int     M_WIDTH    = 48;
	localparam longint T_ONE      = longint'(1) << FRAC_BITS;
	localparam int     CYCLE_LIMIT = 400000;
	localparam int     RANDOM_ITEMS = 1900;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
		logic                         missing;
	} curve_point_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [S_WIDTH-1:0] s_tdata  = '0;
	logic               s_tuser  = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [M_WIDTH-1:0] m_tdata;
	logic               m_tuser;

	logic signed [COORD_BITS-1:0] ctrl_x [NUM_POINTS];
	logic signed [COORD_BITS-1:0] ctrl_y [NUM_POINTS];
	logic signed [COORD_BITS-1:0] ctrl_z [NUM_POINTS];
	logic [NUM_POINTS-1:0]        loaded_mask = '0;
	curve_point_t                 point_queue [$];

	int  error_count = 0;
	int  cycle_count = 0;
	int  rx_hold     = 0;
	logic no_idle    = 1'b0;

	cubic_bezier_point_evaluator #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count > CYCLE_LIMIT);
		$display("tb_cubic_bezier_point_evaluator failed");
		$finish;
	end

	function automatic longint lerp_fixed(longint a, longint b, longint t);
		return a + (((b - a) * t) >>> FRAC_BITS);
	endfunction

	function automatic logic signed [COORD_BITS-1:0] bezier_axis(
		logic signed [COORD_BITS-1:0] c0, logic signed [COORD_BITS-1:0] c1,
		logic signed [COORD_BITS-1:0] c2, logic signed [COORD_BITS-1:0] c3, longint t);
		longint a0, a1, a2, b0, b1;
		a0 = lerp_fixed(c0, c1, t);
		a1 = lerp_fixed(c1, c2, t);
		a2 = lerp_fixed(c2, c3, t);
		b0 = lerp_fixed(a0, a1, t);
		b1 = lerp_fixed(a1, a2, t);
		return COORD_BITS'(lerp_fixed(b0, b1, t));
	endfunction

	function automatic logic [COORD_BITS-1:0] rand_coord();
		case ($urandom_range(0, 15))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return '0;
			3: return '1;
			default: return COORD_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [FRAC_BITS:0] rand_param();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return (FRAC_BITS+1)'(T_ONE);
			2: return (FRAC_BITS+1)'($urandom_range(32'(T_ONE + 1), 32'(2 * T_ONE - 1)));
			default: return (FRAC_BITS+1)'($urandom_range(0, 32'(T_ONE)));
		endcase
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
		error_count++;
	endtask

	task automatic send_item(input logic func, input logic [POINT_IDX_BITS-1:0] idx,
		input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
		input logic [COORD_BITS-1:0] z, input logic [FRAC_BITS:0] t);
		int unsigned  gap;
		logic [95:0]  noise;
		curve_point_t pt;
		longint       tt;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			noise = {$urandom, $urandom, $urandom};
			s_tvalid <= 1'b0;
			s_tdata  <= noise[S_WIDTH-1:0];
			s_tuser  <= noise[95];
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, t, z, y, x, idx};
		s_tuser  <= func;
		do @(posedge clk); while (!s_tready);
		if (func == FUNC_LOAD) begin
			ctrl_x[idx] = x;
			ctrl_y[idx] = y;
			ctrl_z[idx] = z;
			loaded_mask[idx] = 1'b1;
		end else begin
			if (loaded_mask != ALL_LOADED) begin
				pt.x = '0;
				pt.y = '0;
				pt.z = '0;
				pt.missing = 1'b1;
			end else begin
				tt = (longint'(t) > T_ONE) ? T_ONE : longint'(t);
				pt.x = bezier_axis(ctrl_x[0], ctrl_x[1], ctrl_x[2], ctrl_x[3], tt);
				pt.y = bezier_axis(ctrl_y[0], ctrl_y[1], ctrl_y[2], ctrl_y[3], tt);
				pt.z = bezier_axis(ctrl_z[0], ctrl_z[1], ctrl_z[2], ctrl_z[3], tt);
				pt.missing = 1'b0;
			end
			point_queue.insert(point_queue.size(), pt);
		end
	endtask

	initial begin
		int unsigned  wait_cycles;
		curve_point_t want;
		wait (arst_n);
		forever begin
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end else begin
				wait_cycles = no_idle ? 0 : $urandom_range(0, 7);
				if (wait_cycles > 0) begin
					m_tready <= 1'b0;
					repeat (wait_cycles) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (point_queue.size() == 0) begin
				report_mismatch("result with nothing expected, x", $signed(m_tdata[15:0]), 0);
			end else begin
				want = point_queue.pop_front();
				if ($signed(m_tdata[15:0]) != want.x)
					report_mismatch("x_out", $signed(m_tdata[15:0]), want.x);
				if ($signed(m_tdata[31:16]) != want.y)
					report_mismatch("y_out", $signed(m_tdata[31:16]), want.y);
				if ($signed(m_tdata[47:32]) != want.z)
					report_mismatch("z_out", $signed(m_tdata[47:32]), want.z);
				if (m_tuser != want.missing)
					report_mismatch("missing_points", m_tuser, want.missing);
			end
		end
	end

	task automatic test_missing_points();
		send_item(FUNC_EVAL, 2'd0, 16'h0000, 16'h0000, 16'h0000, 17'd0);
		send_item(FUNC_EVAL, 2'd3, 16'hffff, 16'hffff, 16'hffff, 17'h1ffff);
		send_item(FUNC_LOAD, 2'd0, 16'h0100, 16'hff00, 16'h0040, 17'h1ffff);
		send_item(FUNC_LOAD, 2'd1, 16'h0200, 16'h0300, 16'hffc0, 17'd0);
		send_item(FUNC_LOAD, 2'd2, 16'hfe00, 16'h0500, 16'h0010, 17'd5);
		send_item(FUNC_EVAL, 2'd1, 16'h1234, 16'h5678, 16'h9abc, 17'd32768);
	endtask

	task automatic test_extremes();
		send_item(FUNC_LOAD, 2'd0, 16'h8000, 16'h7fff, 16'h0000, 17'd0);
		send_item(FUNC_LOAD, 2'd1, 16'h7fff, 16'h8000, 16'hffff, 17'h1ffff);
		send_item(FUNC_LOAD, 2'd2, 16'h8000, 16'h8000, 16'h7fff, 17'd0);
		send_item(FUNC_LOAD, 2'd3, 16'h7fff, 16'h7fff, 16'h8000, 17'd0);
		send_item(FUNC_EVAL, 2'd0, 16'h0000, 16'h0000, 16'h0000, 17'd0);
		send_item(FUNC_EVAL, 2'd3, 16'hffff, 16'hffff, 16'hffff, 17'd1);
		send_item(FUNC_EVAL, 2'd2, 16'h8000, 16'h7fff, 16'h5555, 17'd32768);
		send_item(FUNC_EVAL, 2'd1, 16'h7fff, 16'h8000, 16'haaaa, 17'd65535);
		send_item(FUNC_EVAL, 2'd0, 16'h0000, 16'hffff, 16'h0000, 17'd65536);
		send_item(FUNC_EVAL, 2'd0, 16'h0000, 16'h0000, 16'h0000, 17'd65537);
		send_item(FUNC_EVAL, 2'd0, 16'h0000, 16'h0000, 16'h0000, 17'h1ffff);
		send_item(FUNC_LOAD, 2'd1, 16'h8000, 16'h7fff, 16'h0001, 17'd0);
		send_item(FUNC_EVAL, 2'd0, 16'h0000, 16'h0000, 16'h0000, 17'd16384);
	endtask

	task automatic test_backpressure();
		s_tvalid <= 1'b0;
		while (point_queue.size() != 0) @(posedge clk);
		no_idle = 1'b1;
		rx_hold = 300;
		repeat (24) send_item(FUNC_EVAL, 2'($urandom), rand_coord(), rand_coord(),
			rand_coord(), rand_param());
		no_idle = 1'b0;
	endtask

	task automatic test_random();
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 150 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 3) == 0)
				send_item(FUNC_LOAD, 2'($urandom), rand_coord(), rand_coord(),
					rand_coord(), 17'($urandom));
			else
				send_item(FUNC_EVAL, 2'($urandom), rand_coord(), rand_coord(),
					rand_coord(), rand_param());
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_missing_points();
		test_extremes();
		test_backpressure();
		test_random();
		s_tvalid <= 1'b0;
		while (point_queue.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("tb_cubic_bezier_point_evaluator passed");
		else
			$display("tb_cubic_bezier_point_evaluator failed");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/cbpe_pkg.sv
hdl/cbpe_front.sv
hdl/cbpe_queue.sv
hdl/cbpe_back.sv
hdl/cubic_bezier_point_evaluator.sv
test/tb_cubic_bezier_point_evaluator.sv
